/* src/bie_pkg.sv */
package bie_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned NumRegs = 16;
  localparam int unsigned RegIdxW = 4;

  localparam logic [1:0] KIND_INSTR = 2'd0;
  localparam logic [1:0] KIND_LOAD_RET = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic [7:0] OP_ADD = 8'h70;
  localparam logic [7:0] OP_SUB = 8'h71;
  localparam logic [7:0] OP_MUL = 8'h72;
  localparam logic [7:0] OP_DIVU = 8'h73;
  localparam logic [7:0] OP_AND = 8'h74;
  localparam logic [7:0] OP_OR = 8'h75;
  localparam logic [7:0] OP_SHL = 8'h76;
  localparam logic [7:0] OP_SHRU = 8'h77;
  localparam logic [7:0] OP_LDW = 8'h78;
  localparam logic [7:0] OP_STW = 8'h79;
  localparam logic [7:0] OP_LDB = 8'h7A;
  localparam logic [7:0] OP_STB = 8'h7B;
  localparam logic [7:0] OP_IMS = 8'h7C;
  localparam logic [7:0] OP_LTU = 8'h7D;
  localparam logic [7:0] OP_JZ = 8'h7E;
  localparam logic [7:0] OP_SYS = 8'h7F;

  localparam logic [2:0] MEM_NONE = 3'd0;
  localparam logic [2:0] MEM_LDW = 3'd1;
  localparam logic [2:0] MEM_LDB = 3'd2;
  localparam logic [2:0] MEM_STW = 3'd3;
  localparam logic [2:0] MEM_STB = 3'd4;

  localparam logic [1:0] TRAP_NONE = 2'd0;
  localparam logic [1:0] TRAP_SYS = 2'd1;
  localparam logic [1:0] TRAP_OPCODE = 2'd2;
  localparam logic [1:0] TRAP_OPERAND = 2'd3;

  localparam logic [4:0] NO_DEST = 5'd16;

  // Item as taken from the input stream
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  opcode;
    logic [7:0]  arg_first;
    logic [7:0]  arg_second;
    logic [7:0]  arg_third;
    logic [31:0] load_value;
  } item_t;

  // Result item
  typedef struct packed {
    logic [31:0] fetch_address;
    logic [2:0]  mem_op;
    logic [31:0] mem_address;
    logic [31:0] store_value;
    logic [4:0]  dest_register;
    logic [31:0] dest_value;
    logic [1:0]  trap;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_item;   // capture input item, read operands
    logic mul_start;
    logic div_start;
    logic commit;       // write register file, load result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_mul;
    logic needs_div;
    logic mul_done;
    logic div_done;
  } dp_status_t;

endpackage

/* src/bytecode_instruction_execute.sv */
// Bytecode instruction executor for a 16-register 32-bit machine.
// Input stream s_axis_*: one beat per item. tuser carries item_kind;
// tdata carries opcode, arg_first, arg_second, arg_third, load_value.
// Output stream m_axis_*: one result beat per input beat, tdata carries
// fetch_address, mem_op, mem_address, store_value, dest_register,
// dest_value; tuser carries trap.
// Multiply uses two 32x16 partial products and unsigned divide a restoring
// divider with one quotient bit per cycle. One item is in flight at a time;
// the next beat is accepted once the previous result has been taken.
// Reset clears the register file, pending load state and all control;
// configuration registers return to start 0, stack 0x01000000, info 4.
// A stalled receiver holds the result in the output register and the
// block accepts nothing until it is taken.
// Config via APB: start_address at 0x0, stack_top 0x4, info_address 0x8.
module bytecode_instruction_execute
  import bie_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode, arg_first, arg_second, arg_third, load_value
  input  logic [63:0]  s_axis_tdata,
  // item_kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fetch_address, mem_op, mem_address, store_value, dest_register, dest_value
  output logic [135:0] m_axis_tdata,
  // trap
  output logic [1:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [3:0] ADDR_START = 4'h0;
  localparam logic [3:0] ADDR_STACK = 4'h4;
  localparam logic [3:0] ADDR_INFO = 4'h8;

  logic [31:0] start_address, stack_top, info_address;
  item_t       item_in;
  result_t     result;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
      stack_top <= 32'h0100_0000;
      info_address <= 32'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_START: start_address <= pwdata;
        ADDR_STACK: stack_top <= pwdata;
        ADDR_INFO:  info_address <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_START: prdata = start_address;
      ADDR_STACK: prdata = stack_top;
      ADDR_INFO:  prdata = info_address;
      default:    prdata = '0;
    endcase
  end

  assign item_in.item_kind = s_axis_tuser;
  assign item_in.opcode = s_axis_tdata[7:0];
  assign item_in.arg_first = s_axis_tdata[15:8];
  assign item_in.arg_second = s_axis_tdata[23:16];
  assign item_in.arg_third = s_axis_tdata[31:24];
  assign item_in.load_value = s_axis_tdata[63:32];

  bie_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .status(status), .cmd(cmd)
  );

  bie_datapath u_dp (
    .clk(clk), .rst(rst), .item_in(item_in), .cmd(cmd),
    .start_address(start_address), .stack_top(stack_top),
    .info_address(info_address), .status(status), .result(result)
  );

  assign m_axis_tdata = {result.dest_value, result.dest_register,
                         result.store_value, result.mem_address, result.mem_op,
                         result.fetch_address};
  assign m_axis_tuser = result.trap;

endmodule

/* src/bie_muldiv.sv */
module bie_muldiv
  import bie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        mul_start,
  input  logic        div_start,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic        mul_done,
  output logic        div_done,
  output logic [31:0] mul_result,
  output logic [31:0] div_result
);

  // Multiply in two 32x16 partial products, one per cycle
  logic        mul_busy;
  logic        mul_phase;
  logic [31:0] mx;
  logic [15:0] my_hi;
  logic [31:0] macc;
  logic [47:0] mprod;

  assign mprod = mx * (mul_phase ? {16'd0, my_hi} : {16'd0, 16'd0}) ;

  // Divide: restoring, one quotient bit per cycle
  logic        div_busy;
  logic [5:0]  div_cnt;
  logic [31:0] dq;
  logic [32:0] drem;
  logic [31:0] dd;
  logic [32:0] dtrial;

  assign dtrial = {drem[31:0], dq[31]} - {1'b0, dd};

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_phase <= 1'b0;
      mul_done <= 1'b0;
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt <= '0;
    end else begin
      mul_done <= 1'b0;
      div_done <= 1'b0;
      if (mul_start) begin
        mul_busy <= 1'b1;
        mul_phase <= 1'b1;
        mx <= x;
        my_hi <= y[31:16];
        macc <= 32'(x * {16'd0, y[15:0]});
      end else if (mul_busy) begin
        macc <= macc + {mprod[15:0], 16'd0};
        mul_busy <= 1'b0;
        mul_phase <= 1'b0;
        mul_done <= 1'b1;
      end
      if (div_start) begin
        div_busy <= 1'b1;
        div_cnt <= 6'd32;
        dq <= x;
        dd <= y;
        drem <= '0;
      end else if (div_busy) begin
        if (dtrial[32]) begin
          drem <= {drem[31:0], dq[31]};
          dq <= {dq[30:0], 1'b0};
        end else begin
          drem <= dtrial;
          dq <= {dq[30:0], 1'b1};
        end
        div_cnt <= div_cnt - 6'd1;
        if (div_cnt == 6'd1) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  assign mul_result = macc;
  // Divide by zero yields all ones naturally from the restoring loop
  assign div_result = dq;

endmodule

/* src/bie_datapath.sv */
module bie_datapath
  import bie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  item_t       item_in,
  input  dp_cmd_t     cmd,
  input  logic [31:0] start_address,
  input  logic [31:0] stack_top,
  input  logic [31:0] info_address,
  output dp_status_t  status,
  output result_t     result
);

  logic [31:0] regs [NumRegs];
  item_t       it;
  logic [3:0]  pending_dest;
  logic        pending_byte_load;

  logic [31:0] ip_adv;
  logic [31:0] v1, v2, v3;
  logic [31:0] x, y;
  logic        mul_done, div_done;
  logic [31:0] mul_result, div_result;
  result_t     res_next;
  logic        wr_en;
  logic [3:0]  wr_idx;
  logic [31:0] wr_val;
  logic [31:0] ip_next;

  assign ip_adv = regs[15] + 32'd4;

  // Decode an operand byte; register 15 reads the advanced IP
  function automatic logic [31:0] mix(input logic [7:0] b, input logic [31:0] r,
                                      input logic [31:0] ipa);
    logic [31:0] v;
    if (b <= 8'h7F) v = {24'd0, b};
    else if (b >= 8'h90) v = {24'hFFFFFF, b};
    else if (b[3:0] == 4'hF) v = ipa;
    else v = r;
    return v;
  endfunction

  assign v1 = mix(it.arg_first, regs[it.arg_first[3:0]], ip_adv);
  assign v2 = mix(it.arg_second, regs[it.arg_second[3:0]], ip_adv);
  assign v3 = mix(it.arg_third, regs[it.arg_third[3:0]], ip_adv);
  assign x = v2;
  assign y = v3;

  assign status.needs_mul = (it.item_kind == KIND_INSTR) && (it.opcode == OP_MUL)
                            && (it.arg_first[7:4] == 4'h8);
  assign status.needs_div = (it.item_kind == KIND_INSTR) && (it.opcode == OP_DIVU)
                            && (it.arg_first[7:4] == 4'h8);
  assign status.mul_done = mul_done;
  assign status.div_done = div_done;

  bie_muldiv u_muldiv (
    .clk(clk), .rst(rst),
    .mul_start(cmd.mul_start), .div_start(cmd.div_start),
    .x(x), .y(y),
    .mul_done(mul_done), .div_done(div_done),
    .mul_result(mul_result), .div_result(div_result)
  );

  // Work out the result of the held item
  always_comb begin
    logic        dest_ok;
    logic [31:0] r;
    logic [31:0] hi;
    dest_ok = (it.arg_first[7:4] == 4'h8);
    r = '0;
    hi = {{24{it.arg_third[7]}}, it.arg_third};
    res_next = '0;
    res_next.dest_register = NO_DEST;
    wr_en = 1'b0;
    wr_idx = it.arg_first[3:0];
    wr_val = '0;
    ip_next = regs[15];
    case (it.item_kind)
      KIND_START: begin
        ip_next = start_address;
      end
      KIND_LOAD_RET: begin
        wr_en = 1'b1;
        wr_idx = pending_dest;
        wr_val = pending_byte_load ? {24'd0, it.load_value[7:0]} : it.load_value;
        res_next.dest_register = {1'b0, pending_dest};
        res_next.dest_value = wr_val;
        if (pending_dest == 4'hF) ip_next = wr_val;
      end
      KIND_INSTR: begin
        ip_next = ip_adv;
        if (it.opcode == OP_SYS) begin
          res_next.trap = TRAP_SYS;
        end else if (it.opcode == OP_STW || it.opcode == OP_STB) begin
          res_next.mem_address = v2 + v3;
          if (it.opcode == OP_STW) begin
            res_next.mem_op = MEM_STW;
            res_next.store_value = v1;
          end else begin
            res_next.mem_op = MEM_STB;
            res_next.store_value = {24'd0, v1[7:0]};
          end
        end else if (it.opcode == OP_IMS) begin
          if (!dest_ok) res_next.trap = TRAP_OPERAND;
          else begin
            // Old register value, advanced IP when the target is register 15
            wr_en = 1'b1;
            wr_val = {v1[15:0], it.arg_third, it.arg_second};
          end
        end else if (it.opcode == OP_JZ) begin
          if (v1 == 32'd0)
            ip_next = ip_adv + {hi[21:0], it.arg_second, 2'b00};
        end else if (!dest_ok) begin
          res_next.trap = TRAP_OPERAND;
        end else begin
          wr_en = 1'b1;
          case (it.opcode)
            OP_ADD:  r = x + y;
            OP_SUB:  r = x - y;
            OP_MUL:  r = mul_result;
            OP_DIVU: r = div_result;
            OP_AND:  r = x & y;
            OP_OR:   r = x | y;
            OP_SHL:  r = (y[31:5] != 27'd0) ? 32'd0 : (x << y[4:0]);
            OP_SHRU: r = (y[31:5] != 27'd0) ? 32'd0 : (x >> y[4:0]);
            OP_LTU:  r = {31'd0, x < y};
            OP_LDW, OP_LDB: begin
              wr_en = 1'b0;
              res_next.mem_op = (it.opcode == OP_LDW) ? MEM_LDW : MEM_LDB;
              res_next.mem_address = x + y;
            end
            default: begin
              wr_en = 1'b0;
              res_next.trap = TRAP_OPCODE;
            end
          endcase
          if (wr_en) wr_val = r;
        end
        if (wr_en) begin
          res_next.dest_register = {1'b0, wr_idx};
          res_next.dest_value = wr_val;
          if (wr_idx == 4'hF) ip_next = wr_val;
        end
        if (res_next.trap != TRAP_NONE) begin
          res_next = '0;
          res_next.trap = (it.opcode == OP_SYS) ? TRAP_SYS :
                          ((!dest_ok && it.opcode != OP_STW && it.opcode != OP_STB
                            && it.opcode != OP_JZ) ? TRAP_OPERAND : TRAP_OPCODE);
          res_next.dest_register = NO_DEST;
          wr_en = 1'b0;
          ip_next = regs[15];
        end
      end
      default: ;
    endcase
    res_next.fetch_address = ip_next;
  end

  // Capture item, commit state and result
  always_ff @(posedge clk) begin
    if (cmd.latch_item) it <= item_in;
    if (rst) begin
      pending_dest <= '0;
      pending_byte_load <= 1'b0;
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else if (cmd.commit) begin
      result <= res_next;
      if (it.item_kind == KIND_START) begin
        // Load the start image: info, stack, entry point twice, rest zero
        for (int i = 0; i < NumRegs; i++) begin
          if (i == 0) regs[i] <= info_address;
          else if (i == 12) regs[i] <= stack_top;
          else if (i >= 14) regs[i] <= start_address;
          else regs[i] <= '0;
        end
        pending_dest <= '0;
        pending_byte_load <= 1'b0;
      end else begin
        regs[15] <= ip_next;
        if (wr_en && wr_idx != 4'hF) regs[wr_idx] <= wr_val;
        if (it.item_kind == KIND_INSTR && res_next.trap == TRAP_NONE &&
            (it.opcode == OP_LDW || it.opcode == OP_LDB)) begin
          pending_dest <= it.arg_first[3:0];
          pending_byte_load <= (it.opcode == OP_LDB);
        end
      end
    end
  end

endmodule

/* src/bie_ctrl.sv */
module bie_ctrl
  import bie_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_DONE} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.latch_item = in_valid && in_ready;
    case (state)
      S_EXEC: begin
        cmd.mul_start = status.needs_mul;
        cmd.div_start = status.needs_div;
        cmd.commit = !status.needs_mul && !status.needs_div;
      end
      S_MUL: cmd.commit = status.mul_done;
      S_DIV: cmd.commit = status.div_done;
      default: ;
    endcase
  end

  // Sequence one item, hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) state <= S_EXEC;
        S_EXEC: begin
          if (status.needs_mul) state <= S_MUL;
          else if (status.needs_div) state <= S_DIV;
          else begin
            state <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        S_MUL: if (status.mul_done) begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        S_DIV: if (status.div_done) begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid) else $error("commit without result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_mul_div_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_start && cmd.div_start)) else $error("both units started");

endmodule

/* bench/tb_bytecode_instruction_execute.sv */
`timescale 1ns / 100ps

module tb_bytecode_instruction_execute
  import bie_pkg::*;
;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // opcode, arg_first, arg_second, arg_third, load_value
  logic [63:0]  s_axis_tdata;
  // item_kind
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // fetch_address, mem_op, mem_address, store_value, dest_register, dest_value
  logic [135:0] m_axis_tdata;
  // trap
  logic [1:0]   m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  localparam int unsigned CycleLimit = 1500000;
  localparam logic [3:0] ADDR_START = 4'h0;
  localparam logic [3:0] ADDR_STACK = 4'h4;
  localparam logic [3:0] ADDR_INFO = 4'h8;
  localparam logic [1:0] KIND_NONE = 2'd3;

  bytecode_instruction_execute u_top (.*);

  // Machine image kept alongside the block
  logic [31:0] cfg_start, cfg_stack, cfg_info;
  logic [31:0] regs [16];
  logic [3:0]  ld_dest;
  logic        ld_byte;
  result_t     expected_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic        hold_off;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard the run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] operand(input logic [7:0] b);
    if (b <= 8'h7F) return {24'd0, b};
    if (b >= 8'h90) return {24'hFFFFFF, b};
    return regs[b[3:0]];
  endfunction

  function automatic logic dest_ok(input logic [7:0] b);
    return b[7:4] == 4'h8;
  endfunction

  // Advance the machine image by one item and return its result
  function automatic result_t execute(input item_t it);
    result_t     r;
    logic [31:0] old_ip, x, y, hi;
    logic        wr;
    r = '0;
    r.dest_register = NO_DEST;
    wr = 1'b0;
    if (it.item_kind == KIND_START) begin
      for (int i = 0; i < 16; i++) regs[i] = '0;
      regs[0] = cfg_info;
      regs[12] = cfg_stack;
      regs[14] = cfg_start;
      regs[15] = cfg_start;
      ld_dest = '0;
      ld_byte = 1'b0;
    end else if (it.item_kind == KIND_LOAD_RET) begin
      r.dest_register = {1'b0, ld_dest};
      r.dest_value = ld_byte ? {24'd0, it.load_value[7:0]} : it.load_value;
      regs[ld_dest] = r.dest_value;
    end else if (it.item_kind == KIND_INSTR) begin
      old_ip = regs[15];
      regs[15] = old_ip + 4;
      x = operand(it.arg_second);
      y = operand(it.arg_third);
      if (it.opcode == OP_SYS) begin
        r.trap = TRAP_SYS;
      end else if (it.opcode == OP_STW || it.opcode == OP_STB) begin
        r.mem_address = x + y;
        r.store_value = operand(it.arg_first);
        if (it.opcode == OP_STW) begin
          r.mem_op = MEM_STW;
        end else begin
          r.mem_op = MEM_STB;
          r.store_value &= 32'hFF;
        end
      end else if (it.opcode == OP_IMS) begin
        if (!dest_ok(it.arg_first)) begin
          r.trap = TRAP_OPERAND;
        end else begin
          r.dest_register = {1'b0, it.arg_first[3:0]};
          r.dest_value = (regs[it.arg_first[3:0]] << 16) | {16'd0, it.arg_third, it.arg_second};
          regs[it.arg_first[3:0]] = r.dest_value;
        end
      end else if (it.opcode == OP_JZ) begin
        if (operand(it.arg_first) == 0) begin
          hi = {{24{it.arg_third[7]}}, it.arg_third};
          regs[15] += ({24'd0, it.arg_second} | (hi << 8)) << 2;
        end
      end else if (!dest_ok(it.arg_first)) begin
        r.trap = TRAP_OPERAND;
      end else begin
        wr = 1'b1;
        case (it.opcode)
          OP_ADD: r.dest_value = x + y;
          OP_SUB: r.dest_value = x - y;
          OP_MUL: r.dest_value = x * y;
          OP_DIVU: r.dest_value = (y == 0) ? 32'hFFFFFFFF : x / y;
          OP_AND: r.dest_value = x & y;
          OP_OR: r.dest_value = x | y;
          OP_SHL: r.dest_value = (y >= 32) ? 32'd0 : x << y[4:0];
          OP_SHRU: r.dest_value = (y >= 32) ? 32'd0 : x >> y[4:0];
          OP_LTU: r.dest_value = {31'd0, x < y};
          OP_LDW, OP_LDB: begin
            wr = 1'b0;
            r.mem_op = (it.opcode == OP_LDW) ? MEM_LDW : MEM_LDB;
            r.mem_address = x + y;
            ld_dest = it.arg_first[3:0];
            ld_byte = (it.opcode == OP_LDB);
          end
          default: begin
            wr = 1'b0;
            r.trap = TRAP_OPCODE;
          end
        endcase
        if (wr) begin
          r.dest_register = {1'b0, it.arg_first[3:0]};
          regs[it.arg_first[3:0]] = r.dest_value;
        end
      end
      if (r.trap != TRAP_NONE) begin
        regs[15] = old_ip;
        r.mem_op = MEM_NONE;
        r.mem_address = '0;
        r.store_value = '0;
        r.dest_register = NO_DEST;
        r.dest_value = '0;
      end
    end
    r.fetch_address = regs[15];
    return r;
  endfunction

  // Offer one beat, with a random gap first now and then
  task automatic send_item(input item_t it);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.item_kind;
    s_axis_tdata <= {it.load_value, it.arg_third, it.arg_second, it.arg_first, it.opcode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_q.push_back(execute(it));
  endtask

  task automatic send_instr(input logic [7:0] op, a1, a2, a3);
    item_t it;
    it = '0;
    it.item_kind = KIND_INSTR;
    it.opcode = op;
    it.arg_first = a1;
    it.arg_second = a2;
    it.arg_third = a3;
    it.load_value = $urandom;
    send_item(it);
  endtask

  task automatic send_kind(input logic [1:0] kind);
    item_t it;
    it = '0;
    it.item_kind = kind;
    it.opcode = $urandom;
    it.arg_first = $urandom;
    it.arg_second = $urandom;
    it.arg_third = $urandom;
    it.load_value = $urandom;
    send_item(it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_START: cfg_start = data;
      ADDR_STACK: cfg_stack = data;
      default: cfg_info = data;
    endcase
  endtask

  function automatic logic [7:0] rand_mix();
    case ($urandom_range(0, 3))
      0: return 8'h80 | 8'($urandom_range(0, 15));
      1: return 8'($urandom_range(0, 8'h7F));
      2: return 8'($urandom_range(8'h90, 8'hFF));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_kind(KIND_START);
    send_instr(OP_ADD, 8'h81, 8'h7F, 8'hFF);
    send_instr(OP_SUB, 8'h82, 8'h00, 8'h90);
    send_instr(OP_MUL, 8'h83, 8'h81, 8'h8C);
    send_instr(OP_DIVU, 8'h84, 8'h8C, 8'h00);
    send_instr(OP_DIVU, 8'h85, 8'hFF, 8'h07);
    send_instr(OP_AND, 8'h86, 8'h8C, 8'hF0);
    send_instr(OP_OR, 8'h87, 8'h80, 8'h8F);
    send_instr(OP_SHL, 8'h88, 8'h7F, 8'h20);
    send_instr(OP_SHL, 8'h88, 8'hFF, 8'h1F);
    send_instr(OP_SHRU, 8'h89, 8'hFF, 8'h20);
    send_instr(OP_LTU, 8'h8A, 8'h01, 8'hFF);
    send_instr(OP_IMS, 8'h8B, 8'hFF, 8'hFF);
    send_instr(OP_IMS, 8'h8F, 8'h34, 8'h12);
    send_instr(OP_IMS, 8'h7F, 8'h00, 8'h00);
    send_instr(OP_STW, 8'h8F, 8'h8C, 8'hFC);
    send_instr(OP_STB, 8'hFF, 8'h80, 8'h00);
    send_instr(OP_LDW, 8'h83, 8'h8E, 8'h04);
    send_kind(KIND_LOAD_RET);
    send_instr(OP_LDB, 8'h8D, 8'h8C, 8'hFF);
    send_kind(KIND_LOAD_RET);
    send_instr(OP_JZ, 8'h00, 8'hFF, 8'h80);
    send_instr(OP_JZ, 8'h01, 8'h10, 8'h7F);
    send_instr(OP_SYS, 8'h80, 8'h00, 8'h00);
    send_instr(8'h00, 8'h80, 8'h00, 8'h00);
    send_instr(8'hFF, 8'h10, 8'h00, 8'h00);
    send_kind(KIND_NONE);
    drain();
  endtask

  task automatic test_random(input int unsigned count);
    logic [7:0] op;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0: send_kind(KIND_START);
        1, 2: send_kind(KIND_LOAD_RET);
        3: send_kind(KIND_NONE);
        4: send_instr(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: begin
          op = OP_ADD + 8'($urandom_range(0, 15));
          // Keep divides rare, they are slow
          if (op == OP_DIVU && $urandom_range(0, 2) != 0) op = OP_ADD;
          send_instr(op, ($urandom_range(0, 15) == 0) ? rand_mix()
                                                         : 8'h80 | 8'($urandom_range(0, 15)),
                     rand_mix(), rand_mix());
        end
      endcase
    end
    drain();
  endtask

  // Stall the output long enough to back up the input
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(20);
    join
  endtask

  task automatic test_config(input logic [31:0] st, sk, inf);
    apb_write(ADDR_START, st);
    apb_write(ADDR_STACK, sk);
    apb_write(ADDR_INFO, inf);
    send_kind(KIND_START);
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else if (cycles[9:8] == 2'b11) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    result_t got, exp;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.fetch_address = m_axis_tdata[31:0];
      got.mem_op = m_axis_tdata[34:32];
      got.mem_address = m_axis_tdata[66:35];
      got.store_value = m_axis_tdata[98:67];
      got.dest_register = m_axis_tdata[103:99];
      got.dest_value = m_axis_tdata[135:104];
      got.trap = m_axis_tuser;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        exp = expected_q.pop_front();
        if (got.fetch_address !== exp.fetch_address) begin
          $error("fetch_address exp %h got %h", exp.fetch_address, got.fetch_address);
          errors++;
        end
        if (got.mem_op !== exp.mem_op) begin
          $error("mem_op exp %0d got %0d", exp.mem_op, got.mem_op);
          errors++;
        end
        if (got.mem_address !== exp.mem_address) begin
          $error("mem_address exp %h got %h", exp.mem_address, got.mem_address);
          errors++;
        end
        if (got.store_value !== exp.store_value) begin
          $error("store_value exp %h got %h", exp.store_value, got.store_value);
          errors++;
        end
        if (got.dest_register !== exp.dest_register) begin
          $error("dest_register exp %0d got %0d", exp.dest_register, got.dest_register);
          errors++;
        end
        if (got.dest_value !== exp.dest_value) begin
          $error("dest_value exp %h got %h", exp.dest_value, got.dest_value);
          errors++;
        end
        if (got.trap !== exp.trap) begin
          $error("trap exp %0d got %0d", exp.trap, got.trap);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    hold_off = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_start = 32'd0;
    cfg_stack = 32'h01000000;
    cfg_info = 32'd4;
    ld_dest = '0;
    ld_byte = 1'b0;
    for (int i = 0; i < 16; i++) regs[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config(32'hFFFFFFFC, 32'hFFFFFFFF, 32'hFFFFFFFF);
    test_random(400);
    test_config(32'd0, 32'd0, 32'd0);
    test_random(400);
    test_backpressure();
    test_config($urandom, $urandom, $urandom);
    test_random(600);
    test_config($urandom, $urandom, $urandom);
    test_random(600);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
